// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the radix digit converter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/rdc_pkg.sv =====
// ----------------------------------------------------------------------------
// rdc_pkg
// Types, constants and helper functions of the radix digit converter.
// ----------------------------------------------------------------------------
package rdc_pkg;

  localparam int VALUE_WIDTH_DEF = 31;
  localparam int STACK_DEPTH_DEF = 32;

  typedef logic [4:0] radix_t;
  typedef logic [3:0] digit_t;
  typedef logic [6:0] char_t;

  localparam radix_t RADIX_RESET = 5'd10;
  localparam radix_t RADIX_MIN   = 5'd2;
  localparam radix_t RADIX_MAX   = 5'd16;

  localparam digit_t DIGIT_LIMIT  = 4'd10;
  localparam char_t  CHAR_ZERO    = 7'h30;
  localparam char_t  CHAR_UPPER_A = 7'h41;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_PUSH,
    ST_READ,
    ST_FETCH,
    ST_SEND
  } state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic push;
    logic pop;
    logic capture;
  } dp_cmd_t;

  typedef struct packed {
    logic div_last;
    logic quot_zero;
    logic out_last;
  } dp_status_t;

  function automatic char_t digit_to_char(digit_t d);
    char_t c;
    if (d < DIGIT_LIMIT) begin
      c = CHAR_ZERO + {3'b000, d};
    end else begin
      c = CHAR_UPPER_A + {3'b000, d} - {3'b000, DIGIT_LIMIT};
    end
    return c;
  endfunction

  function automatic radix_t saturate_radix(radix_t r);
    radix_t b;
    if (r < RADIX_MIN) begin
      b = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      b = RADIX_MAX;
    end else begin
      b = r;
    end
    return b;
  endfunction

endpackage

// ===== rtl/core/rdc_if.sv =====
// ----------------------------------------------------------------------------
// rdc_if
// Valid/ready channel interfaces for the input value and the output digits.
// ----------------------------------------------------------------------------
interface rdc_in_if #(
  parameter int VALUE_WIDTH = rdc_pkg::VALUE_WIDTH_DEF
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface rdc_out_if;
  logic            valid;
  logic            ready;
  rdc_pkg::digit_t digit_value;
  rdc_pkg::char_t  digit_char;
  logic            last_digit;

  modport source (output valid, output digit_value, output digit_char, output last_digit,
                  input ready);
  modport sink   (input valid, input digit_value, input digit_char, input last_digit,
                  output ready);
endinterface

// ===== rtl/core/radix_digit_converter.sv =====
// After a load, the bit-serial divider makes each digit, one quotient bit per cycle,
// and a push follows; each digit out then goes through stack read, capture and present, the
// present step holding until the sink holds ready high. One item at a time: a new value
// is accepted only after the last digit of the previous one is sent.
// Reset: synchronous, active-low rst_n; radix returns to 10, digit stack is not cleared.
// ----------------------------------------------------------------------------
// radix_digit_converter
// Converts a non-negative integer to its digits in a configured base, MSD first.
// ----------------------------------------------------------------------------
module radix_digit_converter #(
  parameter int VALUE_WIDTH = rdc_pkg::VALUE_WIDTH_DEF,
  parameter int STACK_DEPTH = rdc_pkg::STACK_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  rdc_pkg::radix_t  cfg_wr_data,
  rdc_in_if.sink           in_ch,
  rdc_out_if.source        out_ch
);

  import rdc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  rdc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  rdc_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_value        (in_ch.value),
    .cmd             (cmd),
    .status          (status),
    .out_digit_value (out_ch.digit_value),
    .out_digit_char  (out_ch.digit_char),
    .out_last_digit  (out_ch.last_digit)
  );

endmodule

// ===== rtl/core/rdc_ram.sv =====
// ----------------------------------------------------------------------------
// rdc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rdc_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/rdc_ctrl.sv =====
// ----------------------------------------------------------------------------
// rdc_ctrl
// Sequencer for the divide, push and pop phases of one conversion.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rdc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  rdc_pkg::dp_status_t status,
  output rdc_pkg::dp_cmd_t    cmd
);

  import rdc_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (status.div_last) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        state_nxt = status.quot_zero ? ST_READ : ST_DIVIDE;
      end
      ST_READ: begin
        state_nxt = ST_FETCH;
      end
      ST_FETCH: begin
        state_nxt = ST_SEND;
      end
      ST_SEND: begin
        if (out_ready) begin
          state_nxt = status.out_last ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
      end
      ST_PUSH: begin
        cmd.push = 1'b1;
      end
      ST_READ: begin
        cmd.pop = 1'b1;
      end
      ST_FETCH: begin
        cmd.capture = 1'b1;
      end
      ST_SEND: begin
        out_valid = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  `ASSERT_IMP(a_no_overlap, clk, rst_n, out_valid, !in_ready)
  `ASSERT_NXT(a_load_divides, clk, rst_n, in_valid && in_ready, state_r == ST_DIVIDE)
  `ASSERT_NXT(a_div_holds, clk, rst_n, state_r == ST_DIVIDE && !status.div_last,
              state_r == ST_DIVIDE)
  `ASSERT_NXT(a_send_holds, clk, rst_n, out_valid && !out_ready, out_valid)

endmodule

// ===== rtl/core/rdc_datapath.sv =====
// ----------------------------------------------------------------------------
// rdc_datapath
// Bit-serial divider by the radix, digit stack and output digit register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rdc_datapath #(
  parameter int VALUE_WIDTH = rdc_pkg::VALUE_WIDTH_DEF,
  parameter int STACK_DEPTH = rdc_pkg::STACK_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  rdc_pkg::radix_t        cfg_wr_data,
  input  logic [VALUE_WIDTH-1:0] in_value,
  input  rdc_pkg::dp_cmd_t       cmd,
  output rdc_pkg::dp_status_t    status,
  output rdc_pkg::digit_t        out_digit_value,
  output rdc_pkg::char_t         out_digit_char,
  output logic                   out_last_digit
);

  import rdc_pkg::*;

  localparam int BIT_W  = $clog2(VALUE_WIDTH);
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);

  radix_t                 radix_r;
  radix_t                 base_r;
  logic [VALUE_WIDTH-1:0] dq_r;
  digit_t                 rem_r;
  logic [BIT_W-1:0]       bit_cnt_r;
  logic [CNT_W-1:0]       count_r;
  logic                   last_r;
  digit_t                 out_digit_r;
  logic                   out_last_r;

  logic [4:0]             rem_sh;
  logic                   rem_ge;
  digit_t                 rem_nxt;
  logic                   div_last;
  logic                   stack_full;
  logic [CNT_W-1:0]       count_m1;
  digit_t                 ram_rdata;

  assign rem_sh     = {rem_r, dq_r[VALUE_WIDTH-1]};
  assign rem_ge     = (rem_sh >= base_r);
  assign rem_nxt    = rem_ge ? 4'(rem_sh - base_r) : rem_sh[3:0];
  assign div_last   = (bit_cnt_r == BIT_W'(VALUE_WIDTH - 1));
  assign stack_full = (count_r == CNT_W'(STACK_DEPTH));
  assign count_m1   = count_r - CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (cfg_wr_en) begin
      radix_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_cnt_r <= '0;
      count_r   <= '0;
    end else begin
      if (cmd.load) begin
        bit_cnt_r <= '0;
        count_r   <= '0;
      end else if (cmd.div_step) begin
        bit_cnt_r <= div_last ? '0 : bit_cnt_r + BIT_W'(1);
      end else if (cmd.push) begin
        bit_cnt_r <= '0;
        if (!stack_full) begin
          count_r <= count_r + CNT_W'(1);
        end
      end else if (cmd.pop) begin
        count_r <= count_m1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base_r <= saturate_radix(radix_r);
      dq_r   <= in_value;
      rem_r  <= '0;
    end else if (cmd.div_step) begin
      dq_r  <= {dq_r[VALUE_WIDTH-2:0], rem_ge};
      rem_r <= rem_nxt;
    end else if (cmd.push) begin
      rem_r <= '0;
    end
    if (cmd.pop) begin
      last_r <= (count_r == CNT_W'(1));
    end
    if (cmd.capture) begin
      out_digit_r <= ram_rdata;
      out_last_r  <= last_r;
    end
  end

  rdc_ram #(
    .WIDTH ($bits(digit_t)),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (cmd.push && !stack_full),
    .wr_addr (count_r[ADDR_W-1:0]),
    .wr_data (rem_r),
    .rd_en   (cmd.pop),
    .rd_addr (count_m1[ADDR_W-1:0]),
    .rd_data (ram_rdata)
  );

  assign status.div_last  = div_last;
  assign status.quot_zero = (dq_r == '0);
  assign status.out_last  = out_last_r;

  assign out_digit_value = out_digit_r;
  assign out_digit_char  = digit_to_char(out_digit_r);
  assign out_last_digit  = out_last_r;

  `ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(STACK_DEPTH))
  `ASSERT_IMP(a_pop_nonempty, clk, rst_n, cmd.pop, count_r != '0)
  `ASSERT_NXT(a_div_wraps, clk, rst_n, cmd.div_step && div_last, bit_cnt_r == '0)

endmodule
